// ===== rtl/mpwm_pkg.sv =====
package mpwm_pkg;

  // Default configuration of the block.
  localparam int unsigned NumChannels = 10;
  localparam int unsigned CountWidth  = 32;
  localparam int unsigned QueueDepth  = 4;

  // Fixed field widths of the channels and registers.
  localparam int unsigned ActW      = 2;
  localparam int unsigned PinW      = 6;
  localparam int unsigned ValueW    = 32;
  localparam int unsigned PwmW      = 10;
  localparam int unsigned CountOutW = 32;
  localparam int unsigned ChanW     = 4;
  localparam int unsigned ResW      = 16;
  localparam int unsigned TicksW    = 8;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 32;

  // Reset values and limits of the registers.
  localparam logic [CfgDataW-1:0] LimitReset = 32'd1999;
  localparam logic [ResW-1:0]     ResReset   = 16'd100;
  localparam logic [ResW-1:0]     ResMin     = 16'd100;
  localparam logic [TicksW-1:0]   TicksReset = 8'd150;

  // Channel code that marks "no channel written".
  localparam logic [ChanW-1:0] NoChannel = 4'd10;

  // Input action codes.
  typedef enum logic [ActW-1:0] {
    ACT_TICK = 2'd0,
    ACT_DUTY = 2'd1,
    ACT_USEC = 2'd2
  } action_e;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CFG_PERIOD_LIMIT = 2'd0,
    CFG_DUTY_RES     = 2'd1,
    CFG_TICKS_PER_US = 2'd2
  } cfg_idx_e;

  // Classified command kinds handed from the front to the back.
  typedef enum logic [1:0] {
    K_TICK,
    K_DUTY,
    K_USEC,
    K_NOP
  } kind_e;

  typedef struct packed {
    logic [ActW-1:0]   action;
    logic [PinW-1:0]   pin_code;
    logic [ValueW-1:0] write_value;
  } pwm_in_t;

  typedef struct packed {
    logic [PwmW-1:0]      pwm_out;
    logic [CountOutW-1:0] count_now;
    logic [ChanW-1:0]     channel_hit;
  } pwm_out_t;

  typedef struct packed {
    kind_e             kind;
    logic [ChanW-1:0]  chan;
    logic [ValueW-1:0] value;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  // Fixed pin-to-channel table; pins not listed map to no channel.
  function automatic logic [ChanW-1:0] map_pin(input logic [PinW-1:0] code);
    logic [ChanW-1:0] ch;
    case (code)
      6'h02, 6'h11, 6'h24, 6'h37:        ch = 4'd0;
      6'h03, 6'h12, 6'h28, 6'h38:        ch = 4'd1;
      6'h0A, 6'h0F, 6'h13, 6'h29, 6'h39: ch = 4'd2;
      6'h16, 6'h1F, 6'h2A, 6'h3A:        ch = 4'd3;
      6'h17, 6'h23, 6'h31:               ch = 4'd4;
      6'h1A, 6'h32:                      ch = 4'd5;
      6'h1B, 6'h3F:                      ch = 4'd6;
      6'h1C, 6'h33:                      ch = 4'd7;
      6'h1D:                             ch = 4'd8;
      6'h1E:                             ch = 4'd9;
      default:                           ch = NoChannel;
    endcase
    return ch;
  endfunction

endpackage

// ===== rtl/mpwm_front.sv =====
module mpwm_front import mpwm_pkg::*; #(
  parameter int unsigned NUM_CHANNELS = NumChannels
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  input  pwm_in_t in_data_i,
  input  qstat_t  q_stat_i,
  output logic    push_o,
  output cmd_t    cmd_o
);

  logic [ChanW-1:0] chan;
  logic             mapped;
  logic             busy_q;

  // Pin lookup; channels beyond the instantiated count are treated as unmapped.
  assign chan   = map_pin(in_data_i.pin_code);
  assign mapped = (chan != NoChannel) && (32'(chan) < NUM_CHANNELS);

  // Classify the item so the back only sees work it must carry out.
  always_comb begin
    cmd_o.chan  = chan;
    cmd_o.value = in_data_i.write_value;
    case (in_data_i.action)
      ACT_TICK: cmd_o.kind = K_TICK;
      ACT_DUTY: cmd_o.kind = mapped ? K_DUTY : K_NOP;
      ACT_USEC: cmd_o.kind = mapped ? K_USEC : K_NOP;
      default:  cmd_o.kind = K_NOP;
    endcase
  end

  // Hold off new transfers while the queue is full or coming out of reset.
  assign in_stall_o = q_stat_i.full || !busy_q;
  assign push_o     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= 1'b1;
    end
  end

endmodule

// ===== rtl/mpwm_fifo.sv =====
module mpwm_fifo import mpwm_pkg::*; #(
  parameter int unsigned DEPTH = QueueDepth
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  cmd_t   data_i,
  input  logic   pop_i,
  output cmd_t   data_o,
  output qstat_t stat_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  cmd_t            mem_q [DEPTH];
  logic [PtrW-1:0] wr_q;
  logic [PtrW-1:0] rd_q;
  logic [CntW-1:0] cnt_q;

  assign stat_o.full  = (cnt_q == CntW'(DEPTH));
  assign stat_o.empty = (cnt_q == '0);
  assign data_o       = mem_q[rd_q];

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PtrW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == PtrW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (!push_i && pop_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/mpwm_div.sv =====
module mpwm_div import mpwm_pkg::*; #(
  parameter int unsigned DIVIDEND_W = CountWidth + ValueW,
  parameter int unsigned DIVISOR_W  = ResW
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [DIVIDEND_W-1:0] dividend_i,
  input  logic [DIVISOR_W-1:0]  divisor_i,
  output logic                  done_o,
  output logic [DIVIDEND_W-1:0] quotient_o
);

  localparam int unsigned CntW = $clog2(DIVIDEND_W);

  logic                  busy_q;
  logic                  done_q;
  logic [CntW-1:0]       cnt_q;
  logic [DIVISOR_W-1:0]  rem_q;
  logic [DIVIDEND_W-1:0] quo_q;
  logic [DIVISOR_W:0]    shifted;
  logic                  fits;

  // One restoring step: bring down the next dividend bit and try the divisor.
  assign shifted = {rem_q, quo_q[DIVIDEND_W-1]};
  assign fits    = (shifted >= {1'b0, divisor_i});

  assign done_o     = done_q;
  assign quotient_o = quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      rem_q  <= '0;
      quo_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(DIVIDEND_W - 1);
        rem_q  <= '0;
        quo_q  <= dividend_i;
      end else if (busy_q) begin
        rem_q <= fits ? DIVISOR_W'(shifted - {1'b0, divisor_i})
                      : shifted[DIVISOR_W-1:0];
        quo_q <= {quo_q[DIVIDEND_W-2:0], fits};
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== rtl/mpwm_back.sv =====
module mpwm_back import mpwm_pkg::*; #(
  parameter int unsigned NUM_CHANNELS = NumChannels,
  parameter int unsigned COUNT_WIDTH  = CountWidth
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CfgIdxW-1:0]      cfg_idx_i,
  input  logic [CfgDataW-1:0]     cfg_wdata_i,
  input  logic                    q_valid_i,
  output logic                    q_pop_o,
  input  cmd_t                    q_data_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output pwm_out_t                out_data_o,
  output logic [NUM_CHANNELS-1:0] chan_en_o
);

  localparam int unsigned ProdW = COUNT_WIDTH + ValueW;
  localparam int unsigned LvW   = (NUM_CHANNELS > PwmW) ? NUM_CHANNELS : PwmW;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_FIN
  } state_e;

  state_e                  state_q;
  logic [COUNT_WIDTH-1:0]  limit_q;
  logic [ResW-1:0]         res_q;
  logic [TicksW-1:0]       ticks_q;
  logic [COUNT_WIDTH-1:0]  count_q;
  logic [COUNT_WIDTH-1:0]  count_d;
  logic [COUNT_WIDTH-1:0]  active_q [NUM_CHANNELS];
  logic [COUNT_WIDTH-1:0]  shadow_q [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0] en_q;
  logic [NUM_CHANNELS-1:0] levels_q;
  logic [NUM_CHANNELS-1:0] levels_d;
  logic [NUM_CHANNELS-1:0] clr;
  logic [NUM_CHANNELS-1:0] set;
  logic                    wrap_evt;
  kind_e                   kind_q;
  logic [ChanW-1:0]        chan_q;
  logic [ValueW-1:0]       value_q;
  logic [COUNT_WIDTH-1:0]  mul_a;
  logic [ProdW-1:0]        prod_d;
  logic [ProdW-1:0]        prod_q;
  logic                    div_start;
  logic                    div_done;
  logic [ProdW-1:0]        quotient;
  logic [COUNT_WIDTH-1:0]  cmp_d;
  logic                    out_valid_q;
  pwm_out_t                out_data_q;
  logic                    out_free;
  logic [LvW-1:0]          lv_tick;
  logic [LvW-1:0]          lv_hold;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign chan_en_o   = en_q;
  assign out_free    = !out_valid_q || !out_stall_i;

  // Next counter value and per-channel set/clear events of a tick.
  always_comb begin
    count_d  = (count_q == limit_q) ? '0 : count_q + 1'b1;
    wrap_evt = (count_d == limit_q);
    for (int c = 0; c < NUM_CHANNELS; c++) begin
      clr[c] = en_q[c] && (active_q[c] == count_d);
    end
    set      = wrap_evt ? en_q : '0;
    levels_d = (levels_q | (set & ~clr)) & ~(clr & ~set);
    lv_tick  = LvW'(levels_d);
    lv_hold  = LvW'(levels_q);
  end

  // Shared multiplier: period times duty, or ticks per microsecond times width.
  assign mul_a     = (kind_q == K_DUTY) ? limit_q : COUNT_WIDTH'(ticks_q);
  assign prod_d    = mul_a * value_q;
  assign div_start = (state_q == ST_MUL) && (kind_q == K_DUTY);

  mpwm_div #(
    .DIVIDEND_W(ProdW),
    .DIVISOR_W (ResW)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(prod_d),
    .divisor_i (res_q),
    .done_o    (div_done),
    .quotient_o(quotient)
  );

  // Saturated compare value of a finished write.
  always_comb begin
    if (kind_q == K_DUTY) begin
      cmp_d = (quotient > ProdW'(limit_q)) ? limit_q : quotient[COUNT_WIDTH-1:0];
    end else begin
      cmp_d = (|prod_q[ProdW-1:COUNT_WIDTH]) ? '1 : prod_q[COUNT_WIDTH-1:0];
    end
  end

  // Take a command when idle; a command that makes a result at once needs room.
  assign q_pop_o = (state_q == ST_IDLE) && q_valid_i &&
                   (out_free || q_data_i.kind == K_DUTY || q_data_i.kind == K_USEC);

  // Sequencer, timer state and the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      limit_q     <= COUNT_WIDTH'(LimitReset);
      res_q       <= ResReset;
      ticks_q     <= TicksReset;
      count_q     <= '0;
      en_q        <= '0;
      levels_q    <= '0;
      out_valid_q <= 1'b0;
      for (int c = 0; c < NUM_CHANNELS; c++) begin
        active_q[c] <= '0;
        shadow_q[c] <= '0;
      end
    end else begin
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      // Register writes are to arrive only while the block is idle; the block itself does not enforce it.
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_PERIOD_LIMIT: limit_q <= cfg_wdata_i[COUNT_WIDTH-1:0];
          CFG_DUTY_RES: begin
            if (cfg_wdata_i[ResW-1:0] >= ResMin) begin
              res_q <= cfg_wdata_i[ResW-1:0];
            end
          end
          CFG_TICKS_PER_US: ticks_q <= cfg_wdata_i[TicksW-1:0];
          default: ;
        endcase
      end

      case (state_q)
        ST_IDLE: begin
          if (q_pop_o) begin
            kind_q  <= q_data_i.kind;
            chan_q  <= q_data_i.chan;
            value_q <= q_data_i.value;
            case (q_data_i.kind)
              K_TICK: begin
                count_q  <= count_d;
                levels_q <= levels_d;
                if (wrap_evt) begin
                  for (int c = 0; c < NUM_CHANNELS; c++) begin
                    active_q[c] <= shadow_q[c];
                  end
                end
                out_valid_q            <= 1'b1;
                out_data_q.pwm_out     <= lv_tick[PwmW-1:0];
                out_data_q.count_now   <= CountOutW'(count_d);
                out_data_q.channel_hit <= NoChannel;
              end
              K_DUTY, K_USEC: begin
                state_q <= ST_MUL;
              end
              default: begin
                out_valid_q            <= 1'b1;
                out_data_q.pwm_out     <= lv_hold[PwmW-1:0];
                out_data_q.count_now   <= CountOutW'(count_q);
                out_data_q.channel_hit <= NoChannel;
              end
            endcase
          end
        end
        ST_MUL: begin
          prod_q  <= prod_d;
          state_q <= (kind_q == K_DUTY) ? ST_DIV : ST_FIN;
        end
        ST_DIV: begin
          if (div_done) begin
            state_q <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (out_free) begin
            for (int c = 0; c < NUM_CHANNELS; c++) begin
              if (chan_q == ChanW'(c)) begin
                shadow_q[c] <= cmp_d;
                en_q[c]     <= 1'b1;
              end
            end
            out_valid_q            <= 1'b1;
            out_data_q.pwm_out     <= lv_hold[PwmW-1:0];
            out_data_q.count_now   <= CountOutW'(count_q);
            out_data_q.channel_hit <= chan_q;
            state_q                <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/multichannel_pwm_generator.sv =====
// Edge-aligned PWM generator with up to ten channels and shadowed compare values.
// Each tick transfer advances one shared counter that wraps after the period limit;
// at the limit all enabled outputs go high and the compare values load from their
// shadows, and an output goes low when the counter meets its compare value. Ticks
// sustain one transfer per clock while no result is stalled; an input transfer is
// written into the command queue and its result into the output register. A
// microsecond write goes through its take, multiply, and saturate-and-store steps
// in the execution stage. A duty write also passes through the bit-serial divider
// that produces period*duty/resolution one quotient bit per cycle. A four-entry
// command queue lets up to four more transfers arrive while a division is in
// progress. A stalled result holds the execution stage until it is taken. Every
// transfer yields exactly one result transfer, in order.
module multichannel_pwm_generator import mpwm_pkg::*; #(
  parameter int unsigned NUM_CHANNELS = NumChannels,
  parameter int unsigned COUNT_WIDTH  = CountWidth
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  pwm_in_t             in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output pwm_out_t            out_data_o
);

  localparam int unsigned LvW = (NUM_CHANNELS > PwmW) ? NUM_CHANNELS : PwmW;

  qstat_t                  q_stat;
  logic                    q_push;
  logic                    q_pop;
  cmd_t                    q_wdata;
  cmd_t                    q_rdata;
  logic [NUM_CHANNELS-1:0] chan_en;
  logic [LvW-1:0]          en_wide;

  mpwm_front #(
    .NUM_CHANNELS(NUM_CHANNELS)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .in_data_i (in_data_i),
    .q_stat_i  (q_stat),
    .push_o    (q_push),
    .cmd_o     (q_wdata)
  );

  mpwm_fifo #(
    .DEPTH(QueueDepth)
  ) u_fifo (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .push_i(q_push),
    .data_i(q_wdata),
    .pop_i (q_pop),
    .data_o(q_rdata),
    .stat_o(q_stat)
  );

  mpwm_back #(
    .NUM_CHANNELS(NUM_CHANNELS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .q_valid_i  (!q_stat.empty),
    .q_pop_o    (q_pop),
    .q_data_i   (q_rdata),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .chan_en_o  (chan_en)
  );

  assign en_wide = LvW'(chan_en);

  // The result never names a channel beyond the "none" code.
  a_hit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.channel_hit <= NoChannel))
    else $error("channel_hit out of range");

  // Only channels that have been written can drive a high level.
  a_levels_enabled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((out_data_o.pwm_out & ~en_wide[PwmW-1:0]) == '0))
    else $error("output high on a disabled channel");

  // The queue is never full and empty at once.
  a_queue_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_stat.full && q_stat.empty))
    else $error("queue full and empty together");

  // The back only takes a command that is present.
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_stat.empty)
    else $error("pop from an empty queue");

endmodule

// ===== verif/tb_multichannel_pwm_generator.sv =====
module tb_multichannel_pwm_generator;
  import mpwm_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Codes outside the package enums that the block must still tolerate, and the counter's largest value.
  localparam logic [ActW-1:0]    ActUnused   = 2'd3;
  localparam logic [CfgIdxW-1:0] CfgIdxSpare = 2'd3;
  localparam logic [CountWidth-1:0] CountMax = '1;

  localparam int unsigned IdleLimit   = 2000;
  localparam int unsigned IdleSettle  = 4;
  localparam int unsigned EndSettle   = 20;
  localparam int unsigned PhaseItems  = 150;
  localparam int unsigned NumPhases   = 6;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                cfg_we_i    = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i   = '0;
  logic [CfgDataW-1:0] cfg_wdata_i = '0;
  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  pwm_in_t             in_data_i   = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  pwm_out_t            out_data_o;

  multichannel_pwm_generator uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // Free-running clock with a 2 ns period.
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Shadow copy of the block's registers and state, at reset values.
  logic [CountWidth-1:0]  pl_reg  = LimitReset;
  logic [ResW-1:0]        res_reg = ResReset;
  logic [TicksW-1:0]      tpu_reg = TicksReset;
  logic [CountWidth-1:0]  cnt_q   = '0;
  logic [CountWidth-1:0]  act_cmp [NumChannels] = '{default: '0};
  logic [CountWidth-1:0]  shd_cmp [NumChannels] = '{default: '0};
  logic [NumChannels-1:0] lvl_q   = '0;
  logic [NumChannels-1:0] en_q    = '0;

  pwm_out_t        pending_results [$];
  logic [PinW-1:0] mapped_pins [$];
  int unsigned     mismatches   = 0;
  int unsigned     burst_left   = 0;
  int unsigned     stall_mode   = 0;
  int unsigned     stall_span   = 0;
  int unsigned     idle_cycles  = 0;

  // Fixed pin table of the generator, grouped by channel.
  function automatic logic [ChanW-1:0] channel_of_pin(input logic [PinW-1:0] pin);
    case (pin)
      6'h02, 6'h11, 6'h24, 6'h37:        return 4'd0;
      6'h03, 6'h12, 6'h28, 6'h38:        return 4'd1;
      6'h0A, 6'h0F, 6'h13, 6'h29, 6'h39: return 4'd2;
      6'h16, 6'h1F, 6'h2A, 6'h3A:        return 4'd3;
      6'h17, 6'h23, 6'h31:               return 4'd4;
      6'h1A, 6'h32:                      return 4'd5;
      6'h1B, 6'h3F:                      return 4'd6;
      6'h1C, 6'h33:                      return 4'd7;
      6'h1D:                             return 4'd8;
      6'h1E:                             return 4'd9;
      default:                           return NoChannel;
    endcase
  endfunction

  // Advance the shadow state by one input transfer and return the result it produces.
  function automatic pwm_out_t predict_result(input pwm_in_t item);
    logic [NumChannels-1:0] clr;
    logic [NumChannels-1:0] set;
    logic [63:0]            wide;
    logic [ChanW-1:0]       ch;
    pwm_out_t               res;
    int                     c;
    ch = NoChannel;
    case (item.action)
      ACT_TICK: begin
        cnt_q = (cnt_q == pl_reg) ? '0 : cnt_q + 1'b1;
        clr = '0;
        set = '0;
        // Clears look at the compare values that were active before this tick.
        for (c = 0; c < NumChannels; c++) begin
          if (en_q[c] && act_cmp[c] == cnt_q) clr[c] = 1'b1;
        end
        if (cnt_q == pl_reg) begin
          set = en_q;
          for (c = 0; c < NumChannels; c++) act_cmp[c] = shd_cmp[c];
        end
        // A set and a clear on the same tick leave the output as it was.
        lvl_q = (lvl_q | (set & ~clr)) & ~(clr & ~set);
      end
      ACT_DUTY, ACT_USEC: begin
        ch = channel_of_pin(item.pin_code);
        if (ch != NoChannel) begin
          if (item.action == ACT_DUTY) begin
            wide = ({32'd0, pl_reg} * {32'd0, item.write_value}) / {48'd0, res_reg};
            if (wide > {32'd0, pl_reg}) wide = {32'd0, pl_reg};
          end else begin
            wide = {56'd0, tpu_reg} * {32'd0, item.write_value};
            if (wide > {32'd0, CountMax}) wide = {32'd0, CountMax};
          end
          shd_cmp[ch] = wide[CountWidth-1:0];
          en_q[ch]    = 1'b1;
        end
      end
      default: begin
      end
    endcase
    res.pwm_out     = lvl_q;
    res.count_now   = cnt_q;
    res.channel_hit = ch;
    return res;
  endfunction

  // Mostly pins from the table, sometimes any code at all.
  function automatic logic [PinW-1:0] pick_pin();
    logic [PinW-1:0] pin;
    if ($urandom_range(0, 4) == 0) begin
      pin = PinW'($urandom_range(0, 63));
      return pin;
    end
    return mapped_pins[$urandom_range(0, mapped_pins.size() - 1)];
  endfunction

  // Offer one input transfer; the sender runs in bursts with random gaps between them.
  task automatic send_item(input logic [ActW-1:0] act, input logic [PinW-1:0] pin,
                           input logic [ValueW-1:0] val);
    int unsigned gap;
    pwm_in_t     item;
    item.action      = act;
    item.pin_code    = pin;
    item.write_value = val;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      burst_left = $urandom_range(1, 40);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pending_results.push_back(predict_result(item));
    burst_left--;
    @(negedge clk_i);
  endtask

  task automatic send_ticks(input int unsigned count);
    repeat (count) send_item(ACT_TICK, PinW'($urandom_range(0, 63)), $urandom);
  endtask

  // Stop sending and wait until every outstanding result has been received.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (IdleSettle) @(negedge clk_i);
  endtask

  // Register write, issued only once the block has drained.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    case (idx)
      CFG_PERIOD_LIMIT: pl_reg = data[CountWidth-1:0];
      CFG_DUTY_RES:     if (data[ResW-1:0] >= ResMin) res_reg = data[ResW-1:0];
      CFG_TICKS_PER_US: tpu_reg = data[TicksW-1:0];
      default: begin
      end
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // Ticks and ignored writes straight out of reset, at the default period.
  task automatic test_reset_state();
    send_item(ACT_TICK, 6'h00, 32'd0);
    send_item(ACT_TICK, 6'h3F, 32'hFFFF_FFFF);
    send_item(ActUnused, 6'h02, 32'h1234_5678);
    send_item(ACT_DUTY, 6'h00, 32'd50);
    send_item(ACT_USEC, 6'h3E, 32'hFFFF_FFFF);
  endtask

  // Duty writes at zero, mid and saturating values, then ticks across two wraps.
  task automatic test_duty_compare();
    write_reg(CFG_PERIOD_LIMIT, 32'd3);
    send_item(ACT_DUTY, 6'h02, 32'd50);
    send_item(ACT_DUTY, 6'h3F, 32'hFFFF_FFFF);
    send_item(ACT_DUTY, 6'h1E, 32'd0);
    // The second wrap sets and clears channel six on the same tick.
    send_ticks(5);
  endtask

  // Pulse width writes with a zero scale and with a product that saturates.
  task automatic test_usec_scale();
    write_reg(CFG_TICKS_PER_US, 32'd0);
    send_item(ACT_USEC, 6'h11, 32'd7);
    write_reg(CFG_TICKS_PER_US, 32'd255);
    send_item(ACT_USEC, 6'h1D, 32'hFFFF_FFFF);
  endtask

  // Limit lowered below the counter, which then runs on until the limit is raised again.
  task automatic test_counter_above_limit();
    write_reg(CFG_PERIOD_LIMIT, 32'd1);
    send_ticks(1);
    write_reg(CFG_PERIOD_LIMIT, 32'd5);
    send_ticks(2);
  endtask

  // A zero period makes every tick a limit event.
  task automatic test_zero_period();
    write_reg(CFG_PERIOD_LIMIT, 32'd0);
    send_ticks(3);
  endtask

  // Resolution extremes, rejected resolutions, a spare index and the widest period.
  task automatic test_register_extremes();
    write_reg(CFG_DUTY_RES, 32'd65535);
    write_reg(CFG_DUTY_RES, 32'd99);
    write_reg(CFG_DUTY_RES, 32'd0);
    write_reg(CfgIdxSpare, 32'hFFFF_FFFF);
    write_reg(CFG_PERIOD_LIMIT, 32'hFFFF_FFFF);
    send_item(ACT_DUTY, 6'h0A, 32'hFFFF_FFFF);
    send_item(ACT_DUTY, 6'h0A, 32'd65535);
    send_ticks(1);
    write_reg(CFG_TICKS_PER_US, 32'd1);
  endtask

  // Mostly ticks with scattered writes, over several register settings.
  task automatic test_random_traffic();
    int unsigned         phase;
    int unsigned         n;
    int unsigned         roll;
    int unsigned         duty_span;
    int unsigned         usec_span;
    logic [CfgDataW-1:0] lim;
    logic [CfgDataW-1:0] res_v;
    logic [CfgDataW-1:0] tpu_v;
    logic [ValueW-1:0]   val;
    for (phase = 0; phase < NumPhases; phase++) begin
      case (phase)
        0: begin
          lim = 15; res_v = 100; tpu_v = 1;
        end
        1: begin
          lim = $urandom_range(1, 40); res_v = $urandom_range(100, 65535);
          tpu_v = $urandom_range(2, 254);
        end
        2: begin
          lim = 0; res_v = $urandom_range(100, 1000); tpu_v = $urandom_range(0, 3);
        end
        3: begin
          lim = 100; res_v = 65535; tpu_v = 255;
        end
        4: begin
          lim = $urandom_range(2, 60); res_v = 100; tpu_v = 0;
        end
        default: begin
          lim = '1; res_v = $urandom_range(100, 65535); tpu_v = $urandom_range(1, 255);
        end
      endcase
      // Park the limit on the counter so the next tick wraps it to zero.
      if (cnt_q > lim) begin
        write_reg(CFG_PERIOD_LIMIT, cnt_q);
        send_ticks(1);
      end
      write_reg(CFG_PERIOD_LIMIT, lim);
      write_reg(CFG_DUTY_RES, res_v);
      write_reg(CFG_TICKS_PER_US, tpu_v);
      duty_span = res_reg;
      duty_span = duty_span + duty_span / 4;
      usec_span = (lim > 1000) ? 1000 : lim;
      usec_span = usec_span / ((tpu_reg == 0) ? 1 : tpu_reg) + 1;
      for (n = 0; n < PhaseItems; n++) begin
        roll = $urandom_range(0, 99);
        if (roll < 6) begin
          val = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, duty_span);
          send_item(ACT_DUTY, pick_pin(), val);
        end else if (roll < 11) begin
          val = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, usec_span);
          send_item(ACT_USEC, pick_pin(), val);
        end else if (roll < 12) begin
          send_item(ActUnused, PinW'($urandom_range(0, 63)), $urandom);
        end else begin
          send_ticks(1);
        end
      end
    end
  endtask

  // Receiver back-pressure: free, light, heavy and periodic stretches.
  always @(negedge clk_i) begin
    if (stall_span == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_span = $urandom_range(10, 80);
    end
    stall_span--;
    case (stall_mode)
      0:       out_stall_i <= 1'b0;
      1:       out_stall_i <= ($urandom_range(0, 3) == 0);
      2:       out_stall_i <= ($urandom_range(0, 1) == 0);
      default: out_stall_i <= (stall_span % 8) < 5;
    endcase
  end

  // Compare each result transfer with the oldest prediction.
  always @(posedge clk_i) begin
    pwm_out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        $display("%0t: result with nothing pending, got %h", $time, out_data_o);
      end else begin
        want = pending_results.pop_front();
        if (out_data_o.pwm_out !== want.pwm_out) begin
          mismatches++;
          $display("%0t: pwm_out expected %h, actual %h", $time, want.pwm_out,
                   out_data_o.pwm_out);
        end
        if (out_data_o.count_now !== want.count_now) begin
          mismatches++;
          $display("%0t: count_now expected %h, actual %h", $time, want.count_now,
                   out_data_o.count_now);
        end
        if (out_data_o.channel_hit !== want.channel_hit) begin
          mismatches++;
          $display("%0t: channel_hit expected %h, actual %h", $time, want.channel_hit,
                   out_data_o.channel_hit);
        end
      end
    end
  end

  // End the run when no transfer of any kind has happened for too long.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_we_i) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IdleLimit) begin
      $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    int p;
    for (p = 0; p < 64; p++) begin
      if (channel_of_pin(p[PinW-1:0]) != NoChannel) mapped_pins.push_back(p[PinW-1:0]);
    end
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    test_reset_state();
    test_duty_compare();
    test_usec_scale();
    test_counter_above_limit();
    test_zero_period();
    test_register_extremes();
    test_random_traffic();
    wait_idle();
    repeat (EndSettle) @(negedge clk_i);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
